// File: hdl/lcsc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lru cache set with cost
package lcsc_pkg;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_INVAL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WAYS_IN_USE      = 2'd0;
    localparam logic [1:0] CFG_HIT_COST         = 2'd1;
    localparam logic [1:0] CFG_FETCH_COST       = 2'd2;
    localparam logic [1:0] CFG_DIRTY_EVICT_COST = 2'd3;

    // configuration reset values
    localparam logic [3:0] RST_WAYS_IN_USE      = 4'd8;
    localparam logic [9:0] RST_HIT_COST         = 10'd1;
    localparam logic [9:0] RST_FETCH_COST       = 10'd100;
    localparam logic [9:0] RST_DIRTY_EVICT_COST = 10'd100;

    localparam logic [10:0] COST_TOP = 11'd2047;

    // way index and rank wide enough for the largest set
    typedef logic [4:0] t_way_idx;
    typedef logic [4:0] t_rank;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] tag;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic        evicted_dirty;
        logic [10:0] cycle_cost;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_DROP,
        UPD_TOUCH,
        UPD_FILL
    } t_upd_op;

    // update request from the controller to the way state
    typedef struct packed {
        t_upd_op  op;
        t_way_idx way;       // way dropped or touched
        t_rank    ref_rank;  // rank of that way, or of the victim on a fill
        logic     evict;
        t_way_idx victim;
        t_way_idx fill_way;
        logic     set_dirty;
    } t_upd;

    // status of the way picked by the scan
    typedef struct packed {
        logic  valid;
        logic  dirty;
        t_rank rank;
    } t_way_stat;

endpackage

// File: hdl/lcsc_tag_ram.sv
`timescale 1ns / 1ps
// tag memory: one write port, one read port with registered data
module lcsc_tag_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lcsc_way_state.sv
`timescale 1ns / 1ps
// per-way valid, dirty and recency rank flops with the lru update logic
module lcsc_way_state #(
    parameter int MAX_WAYS = 8,
    parameter int WAY_W    = 3,
    parameter int OCC_W    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcsc_pkg::t_upd     i_upd,
    input  logic [WAY_W-1:0]   i_sel_way,
    output lcsc_pkg::t_way_stat o_stat,
    output logic [OCC_W-1:0]   o_occ
);

    localparam int RANK_W = WAY_W;

    logic [MAX_WAYS-1:0] r_valid, n_valid;
    logic [MAX_WAYS-1:0] r_dirty, n_dirty;
    logic [RANK_W-1:0]   r_rank [MAX_WAYS];
    logic [RANK_W-1:0]   n_rank [MAX_WAYS];
    logic [OCC_W-1:0]    r_occ, n_occ;

    always_comb begin
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_rank  = r_rank;
        n_occ   = r_occ;
        case (i_upd.op)
            lcsc_pkg::UPD_DROP: begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (lcsc_pkg::t_way_idx'(w) == i_upd.way) begin
                        n_valid[w] = 1'b0;
                        n_dirty[w] = 1'b0;
                        n_rank[w]  = '0;
                    end else if (r_valid[w] &&
                                 lcsc_pkg::t_rank'(r_rank[w]) > i_upd.ref_rank) begin
                        n_rank[w] = r_rank[w] - RANK_W'(1);
                    end
                end
                if (r_occ != '0) begin
                    n_occ = r_occ - OCC_W'(1);
                end
            end
            lcsc_pkg::UPD_TOUCH: begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (lcsc_pkg::t_way_idx'(w) == i_upd.way) begin
                        n_rank[w]  = '0;
                        n_dirty[w] = r_dirty[w] | i_upd.set_dirty;
                    end else if (r_valid[w] &&
                                 lcsc_pkg::t_rank'(r_rank[w]) < i_upd.ref_rank) begin
                        n_rank[w] = r_rank[w] + RANK_W'(1);
                    end
                end
            end
            lcsc_pkg::UPD_FILL: begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (lcsc_pkg::t_way_idx'(w) == i_upd.fill_way) begin
                        n_valid[w] = 1'b1;
                        n_dirty[w] = i_upd.set_dirty;
                        n_rank[w]  = '0;
                    end else if (i_upd.evict &&
                                 lcsc_pkg::t_way_idx'(w) == i_upd.victim) begin
                        n_valid[w] = 1'b0;
                        n_dirty[w] = 1'b0;
                        n_rank[w]  = '0;
                    end else if (r_valid[w]) begin
                        // close the victim's gap, then age behind the new line
                        if (i_upd.evict &&
                            lcsc_pkg::t_rank'(r_rank[w]) > i_upd.ref_rank) begin
                            n_rank[w] = r_rank[w];
                        end else begin
                            n_rank[w] = r_rank[w] + RANK_W'(1);
                        end
                    end
                end
                if (!i_upd.evict) begin
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_occ   <= '0;
            for (int w = 0; w < MAX_WAYS; w++) begin
                r_rank[w] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_rank  <= n_rank;
            r_occ   <= n_occ;
        end
    end

    assign o_stat.valid = r_valid[i_sel_way];
    assign o_stat.dirty = r_dirty[i_sel_way];
    assign o_stat.rank  = lcsc_pkg::t_rank'(r_rank[i_sel_way]);
    assign o_occ        = r_occ;

endmodule

// File: hdl/lru_cache_set_with_cost_core.sv
`timescale 1ns / 1ps
// top level of one lru cache set that charges a cycle cost per access
//
// usage
//   - command channel: present i_item (command, tag) with start high; it is
//     taken at a rising edge where start is high and busy is low
//   - result channel: o_result is shown for exactly one cycle with
//     o_result_valid high; the receiver cannot stall it and must take it
//   - config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//     i_cfg_data; ready is always high, write only while the block is idle
//   - timing: the tag memory is scanned one way per cycle through its
//     registered read port, then the update state follows; the result
//     appears in the cycle after the update, and a new item can be taken
//     in that same cycle
//   - reset (synchronous, active low) empties the set, clears all ranks and
//     loads the default costs and associativity; the tag memory keeps its
//     contents since tags are only compared on valid ways
module lru_cache_set_with_cost_core #(
    parameter int MAX_WAYS = 8,
    parameter int TAG_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  lcsc_pkg::t_in_item   i_item,
    // result channel
    output logic                 o_result_valid,
    output lcsc_pkg::t_out_item  o_result,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [9:0]           i_cfg_data
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int OCC_W = $clog2(MAX_WAYS + 1);
    localparam int CNT_W = $clog2(MAX_WAYS + 1);
    localparam int TW    = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int CW    = (OCC_W > 4) ? OCC_W : 4;

    // fsm
    lcsc_pkg::t_state r_state, n_state;

    // item being worked on
    logic [1:0]    r_cmd;
    logic [TW-1:0] r_tag;

    // scan pipeline: read issue counter and registered compare slot
    logic [CNT_W-1:0] r_cnt;
    logic             r_chk_en;
    logic [WAY_W-1:0] r_chk_way;
    logic             scan_issue;
    logic             scan_last;
    logic             accept;

    // scan findings
    logic                r_hit_found;
    logic [WAY_W-1:0]    r_hit_way;
    lcsc_pkg::t_rank     r_hit_rank;
    logic                r_vic_found;
    logic [WAY_W-1:0]    r_vic_way;
    lcsc_pkg::t_rank     r_vic_rank;
    logic                r_vic_dirty;
    logic                r_free_found;
    logic [WAY_W-1:0]    r_free_way;

    // configuration registers
    logic [3:0] r_ways_in_use;
    logic [9:0] r_hit_cost;
    logic [9:0] r_fetch_cost;
    logic [9:0] r_dirty_evict_cost;

    // result register
    logic                r_result_valid;
    lcsc_pkg::t_out_item r_result, n_result;

    // links to the memory and the way state
    logic [TW-1:0]        rd_tag;
    lcsc_pkg::t_way_stat  chk_stat;
    logic [OCC_W-1:0]     occ;
    lcsc_pkg::t_upd       upd;
    logic                 tag_we;
    logic [WAY_W-1:0]     tag_waddr;

    // update decision helpers
    logic [CW-1:0]  eff_ways;
    logic           need_evict;
    logic           fill_ok;
    logic [WAY_W-1:0] fill_way;
    logic [11:0]    miss_cost;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    lcsc_tag_ram #(
        .DEPTH (MAX_WAYS),
        .WIDTH (TW),
        .AW    (WAY_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_tag),
        .i_raddr (r_cnt[WAY_W-1:0]),
        .o_rdata (rd_tag)
    );

    lcsc_way_state #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W),
        .OCC_W    (OCC_W)
    ) u_way_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_sel_way (r_chk_way),
        .o_stat    (chk_stat),
        .o_occ     (occ)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcsc_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lcsc_pkg::ST_SCAN;
                end
            end
            lcsc_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = lcsc_pkg::ST_UPDATE;
                end
            end
            lcsc_pkg::ST_UPDATE: begin
                n_state = lcsc_pkg::ST_IDLE;
            end
            default: begin
                n_state = lcsc_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        busy       = 1'b1;
        scan_issue = 1'b0;
        case (r_state)
            lcsc_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            lcsc_pkg::ST_SCAN: begin
                scan_issue = (r_cnt < CNT_W'(MAX_WAYS));
            end
            default: begin
            end
        endcase
    end

    assign scan_last = (r_state == lcsc_pkg::ST_SCAN) && r_chk_en &&
                       (r_chk_way == WAY_W'(MAX_WAYS - 1));

    // associativity clamped to one .. MAX_WAYS
    always_comb begin
        if (r_ways_in_use == 4'd0) begin
            eff_ways = CW'(1);
        end else if (CW'(r_ways_in_use) > CW'(MAX_WAYS)) begin
            eff_ways = CW'(MAX_WAYS);
        end else begin
            eff_ways = CW'(r_ways_in_use);
        end
    end

    assign need_evict = (CW'(occ) >= eff_ways) && r_vic_found;

    // first free way once the victim is gone
    always_comb begin
        fill_ok  = r_free_found || need_evict;
        fill_way = r_free_way;
        if (need_evict && (!r_free_found || r_vic_way < r_free_way)) begin
            fill_way = r_vic_way;
        end
    end

    assign miss_cost = {2'b00, r_fetch_cost} +
                       ((need_evict && r_vic_dirty) ? {2'b00, r_dirty_evict_cost} : 12'd0);

    // decision taken in the update cycle
    always_comb begin
        upd            = '0;
        upd.op         = lcsc_pkg::UPD_NONE;
        n_result       = '0;
        tag_we         = 1'b0;
        tag_waddr      = fill_way;
        if (r_state == lcsc_pkg::ST_UPDATE) begin
            if (r_cmd == lcsc_pkg::CMD_INVAL) begin
                if (r_hit_found) begin
                    n_result.hit = 1'b1;
                    upd.op       = lcsc_pkg::UPD_DROP;
                    upd.way      = lcsc_pkg::t_way_idx'(r_hit_way);
                    upd.ref_rank = r_hit_rank;
                end
            end else if (r_cmd == lcsc_pkg::CMD_READ || r_cmd == lcsc_pkg::CMD_WRITE) begin
                upd.set_dirty = (r_cmd == lcsc_pkg::CMD_WRITE);
                if (r_hit_found) begin
                    n_result.hit        = 1'b1;
                    n_result.cycle_cost = {1'b0, r_hit_cost};
                    upd.op              = lcsc_pkg::UPD_TOUCH;
                    upd.way             = lcsc_pkg::t_way_idx'(r_hit_way);
                    upd.ref_rank        = r_hit_rank;
                end else begin
                    n_result.evicted       = need_evict;
                    n_result.evicted_dirty = need_evict && r_vic_dirty;
                    n_result.cycle_cost    = (miss_cost > {1'b0, lcsc_pkg::COST_TOP}) ?
                                             lcsc_pkg::COST_TOP : miss_cost[10:0];
                    upd.evict    = need_evict;
                    upd.victim   = lcsc_pkg::t_way_idx'(r_vic_way);
                    upd.ref_rank = r_vic_rank;
                    upd.way      = lcsc_pkg::t_way_idx'(r_vic_way);
                    upd.fill_way = lcsc_pkg::t_way_idx'(fill_way);
                    if (fill_ok) begin
                        upd.op = lcsc_pkg::UPD_FILL;
                        tag_we = 1'b1;
                    end else if (need_evict) begin
                        upd.op = lcsc_pkg::UPD_DROP;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lcsc_pkg::ST_IDLE;
            r_cnt          <= '0;
            r_chk_en       <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= (r_state == lcsc_pkg::ST_UPDATE);
            r_chk_en       <= scan_issue;
            if (accept) begin
                r_cnt <= '0;
            end else if (scan_issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use      <= lcsc_pkg::RST_WAYS_IN_USE;
            r_hit_cost         <= lcsc_pkg::RST_HIT_COST;
            r_fetch_cost       <= lcsc_pkg::RST_FETCH_COST;
            r_dirty_evict_cost <= lcsc_pkg::RST_DIRTY_EVICT_COST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lcsc_pkg::CFG_WAYS_IN_USE:      r_ways_in_use      <= i_cfg_data[3:0];
                lcsc_pkg::CFG_HIT_COST:         r_hit_cost         <= i_cfg_data;
                lcsc_pkg::CFG_FETCH_COST:       r_fetch_cost       <= i_cfg_data;
                lcsc_pkg::CFG_DIRTY_EVICT_COST: r_dirty_evict_cost <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // item, scan findings and result payload
    always_ff @(posedge i_clk) begin
        r_chk_way <= r_cnt[WAY_W-1:0];
        if (r_state == lcsc_pkg::ST_UPDATE) begin
            r_result <= n_result;
        end
        if (accept) begin
            r_cmd        <= i_item.command;
            r_tag        <= i_item.tag[TW-1:0];
            r_hit_found  <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_chk_en) begin
            // lowest matching way wins
            if (chk_stat.valid && rd_tag == r_tag && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_way   <= r_chk_way;
                r_hit_rank  <= chk_stat.rank;
            end
            // oldest valid way is the victim
            if (chk_stat.valid && (!r_vic_found || chk_stat.rank > r_vic_rank)) begin
                r_vic_found <= 1'b1;
                r_vic_way   <= r_chk_way;
                r_vic_rank  <= chk_stat.rank;
                r_vic_dirty <= chk_stat.dirty;
            end
            if (!chk_stat.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_way   <= r_chk_way;
            end
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    // a result only follows an update cycle
    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == lcsc_pkg::ST_UPDATE))
        else $error("result strobe without an update cycle");

    // every finished item gives its result as the block frees up
    a_done_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("block went idle without a result");

    // occupancy stays within the set
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= OCC_W'(MAX_WAYS))
        else $error("occupancy above way count");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.hit && o_result.evicted))
        else $error("hit with eviction");

    // dirty eviction implies an eviction
    a_dirty_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.evicted_dirty |-> o_result.evicted)
        else $error("dirty flag without eviction");

endmodule

// File: tb/lru_cache_set_with_cost_checker.sv
`timescale 1ns / 1ps
// checker for the lru cache set: watches all channels, predicts each access result and compares
module lru_cache_set_with_cost_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  lcsc_pkg::t_in_item  i_item,
    input  logic                i_res_valid,
    input  lcsc_pkg::t_out_item i_result,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    output int                  o_err_count,
    output int                  o_pending,
    output int                  o_n_access,
    output int                  o_n_hit,
    output int                  o_n_evict,
    output int                  o_n_dirty_evict
);

    localparam int SET_WAYS = 8;

    // shadow copy of the set
    logic [31:0] line_tag   [SET_WAYS];
    logic        line_valid [SET_WAYS];
    logic        line_dirty [SET_WAYS];
    int unsigned line_rank  [SET_WAYS];
    int unsigned lines_held;

    // shadow copy of the registers
    logic [3:0] assoc;
    logic [9:0] cost_hit;
    logic [9:0] cost_fetch;
    logic [9:0] cost_dirty;

    lcsc_pkg::t_out_item pending_results[$];

    // remove a valid line and close the rank gap behind it
    function automatic void drop_line(input int victim);
        int unsigned r;
        int w;
        r = line_rank[victim];
        for (w = 0; w < SET_WAYS; w++) begin
            if (line_valid[w] && w != victim && line_rank[w] > r)
                line_rank[w]--;
        end
        line_valid[victim] = 1'b0;
        line_dirty[victim] = 1'b0;
        line_rank[victim]  = 0;
        if (lines_held > 0)
            lines_held--;
    endfunction

    // apply one access to the shadow set and return its result
    function automatic lcsc_pkg::t_out_item access_set(input lcsc_pkg::t_in_item it);
        lcsc_pkg::t_out_item res;
        int          found;
        int          victim;
        int          free_way;
        int          w;
        int unsigned cap;
        int unsigned cost;
        int unsigned r;
        res   = '0;
        cost  = 0;
        found = -1;
        for (w = 0; w < SET_WAYS; w++) begin
            if (found < 0 && line_valid[w] && line_tag[w] == it.tag)
                found = w;
        end
        case (it.command)
            lcsc_pkg::CMD_INVAL: begin
                if (found >= 0) begin
                    res.hit = 1'b1;
                    drop_line(found);
                end
            end
            lcsc_pkg::CMD_READ, lcsc_pkg::CMD_WRITE: begin
                if (found >= 0) begin
                    res.hit = 1'b1;
                    cost    = cost_hit;
                    r       = line_rank[found];
                    for (w = 0; w < SET_WAYS; w++) begin
                        if (line_valid[w] && w != found && line_rank[w] < r)
                            line_rank[w]++;
                    end
                    line_rank[found] = 0;
                end else begin
                    cost = cost_fetch;
                    cap  = (assoc == 0) ? 1 : (assoc > SET_WAYS) ? SET_WAYS : assoc;
                    if (lines_held >= cap) begin
                        victim = -1;
                        for (w = 0; w < SET_WAYS; w++) begin
                            if (line_valid[w] &&
                                (victim < 0 || line_rank[w] > line_rank[victim]))
                                victim = w;
                        end
                        if (victim >= 0) begin
                            res.evicted = 1'b1;
                            if (line_dirty[victim]) begin
                                res.evicted_dirty = 1'b1;
                                cost += cost_dirty;
                            end
                            drop_line(victim);
                        end
                    end
                    free_way = -1;
                    for (w = 0; w < SET_WAYS; w++) begin
                        if (free_way < 0 && !line_valid[w])
                            free_way = w;
                    end
                    if (free_way >= 0) begin
                        for (w = 0; w < SET_WAYS; w++) begin
                            if (line_valid[w])
                                line_rank[w]++;
                        end
                        line_tag[free_way]   = it.tag;
                        line_valid[free_way] = 1'b1;
                        line_dirty[free_way] = 1'b0;
                        line_rank[free_way]  = 0;
                        lines_held++;
                        found = free_way;
                    end
                end
                if (it.command == lcsc_pkg::CMD_WRITE && found >= 0)
                    line_dirty[found] = 1'b1;
                if (cost > lcsc_pkg::COST_TOP)
                    cost = lcsc_pkg::COST_TOP;
            end
            default: begin
            end
        endcase
        res.cycle_cost = cost[10:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        lcsc_pkg::t_out_item want;
        lcsc_pkg::t_out_item got;
        if (!i_rst_n) begin
            for (int w = 0; w < SET_WAYS; w++) begin
                line_tag[w]   = '0;
                line_valid[w] = 1'b0;
                line_dirty[w] = 1'b0;
                line_rank[w]  = 0;
            end
            lines_held      = 0;
            assoc           = lcsc_pkg::RST_WAYS_IN_USE;
            cost_hit        = lcsc_pkg::RST_HIT_COST;
            cost_fetch      = lcsc_pkg::RST_FETCH_COST;
            cost_dirty      = lcsc_pkg::RST_DIRTY_EVICT_COST;
            o_err_count     = 0;
            o_n_access      = 0;
            o_n_hit         = 0;
            o_n_evict       = 0;
            o_n_dirty_evict = 0;
            pending_results.delete();
        end else begin
            if (i_res_valid) begin
                got = i_result;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no access outstanding: got %p", $time, got);
                    o_err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.hit !== want.hit || got.evicted !== want.evicted ||
                        got.evicted_dirty !== want.evicted_dirty ||
                        got.cycle_cost !== want.cycle_cost) begin
                        $display("%0t: result mismatch: expected hit %0b ev %0b evd %0b cost %0d",
                                 $time, want.hit, want.evicted, want.evicted_dirty,
                                 want.cycle_cost);
                        $display("%0t:                  actual   hit %0b ev %0b evd %0b cost %0d",
                                 $time, got.hit, got.evicted, got.evicted_dirty,
                                 got.cycle_cost);
                        o_err_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lcsc_pkg::CFG_WAYS_IN_USE:      assoc      = i_cfg_data[3:0];
                    lcsc_pkg::CFG_HIT_COST:         cost_hit   = i_cfg_data;
                    lcsc_pkg::CFG_FETCH_COST:       cost_fetch = i_cfg_data;
                    lcsc_pkg::CFG_DIRTY_EVICT_COST: cost_dirty = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                want = access_set(i_item);
                pending_results.push_back(want);
                o_n_access++;
                if (want.hit)
                    o_n_hit++;
                if (want.evicted)
                    o_n_evict++;
                if (want.evicted_dirty)
                    o_n_dirty_evict++;
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// File: tb/lru_cache_set_with_cost_core_tb.sv
`timescale 1ns / 1ps
// testbench top for the lru cache set: stimulus, configuration phases and verdict
module lru_cache_set_with_cost_core_tb;

    // command 3 is not a real operation, the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ACCESSES = 1350;
    localparam int SETTLE_CYCLES   = 14;     // one full access plus margin
    localparam int STALL_LIMIT     = 2000;   // cycles with no transfer at all
    localparam int POOL_MAX        = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    lcsc_pkg::t_in_item  i_item;
    logic                o_result_valid;
    lcsc_pkg::t_out_item o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [9:0]          i_cfg_data;

    int err_count;
    int pending;
    int n_access;
    int n_hit;
    int n_evict;
    int n_dirty_evict;

    // stimulus knobs, changed per phase
    logic [31:0] tag_pool [POOL_MAX];
    int          pool_len;
    bit          gaps_on;
    int          n_phase;
    int          idle_cycles;

    lru_cache_set_with_cost_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    lru_cache_set_with_cost_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (i_item),
        .i_res_valid     (o_result_valid),
        .i_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_err_count     (err_count),
        .o_pending       (pending),
        .o_n_access      (n_access),
        .o_n_hit         (n_hit),
        .o_n_evict       (n_evict),
        .o_n_dirty_evict (n_dirty_evict)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("lru_cache_set_with_cost_core_tb: done, errors");
            $finish;
        end
    end

    // idle cycles before the next command, none when idling is off for the phase
    function automatic int unsigned pick_gap();
        return gaps_on ? $urandom_range(0, 9) : 0;
    endfunction

    // present one command and hold it until the block takes it; start stays
    // high afterwards so a back-to-back command needs no extra edge
    task automatic issue_access(input logic [1:0] cmd, input logic [31:0] tag);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= lcsc_pkg::t_in_item'{command: cmd, tag: tag};
        do @(posedge i_clk); while (busy);
    endtask

    // drop start and wait until every outstanding result has come back and
    // the block has had time to finish its last update
    task automatic drain_set();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register transfer; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // full register set, only ever done with the block drained
    task automatic configure(input logic [9:0] ways_word, input logic [9:0] hit_c,
                             input logic [9:0] fetch_c, input logic [9:0] dirty_c);
        drain_set();
        write_reg(lcsc_pkg::CFG_WAYS_IN_USE, ways_word);
        write_reg(lcsc_pkg::CFG_HIT_COST, hit_c);
        write_reg(lcsc_pkg::CFG_FETCH_COST, fetch_c);
        write_reg(lcsc_pkg::CFG_DIRTY_EVICT_COST, dirty_c);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_phase++;
    endtask

    // cost value biased toward the ends of its range
    function automatic logic [9:0] pick_cost();
        case ($urandom_range(0, 3))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // associativity in the low nibble, random junk above it; 0, 1, 8 and
    // 15 get extra weight
    function automatic logic [9:0] pick_ways_word();
        logic [3:0] w;
        case ($urandom_range(0, 5))
            0:       w = 4'd0;
            1:       w = 4'd15;
            2:       w = 4'd1;
            3:       w = 4'd8;
            default: w = 4'($urandom_range(0, 15));
        endcase
        return {6'($urandom_range(0, 63)), w};
    endfunction

    // small tag pools give many hits and evictions, larger ones mostly misses
    task automatic refill_pool();
        pool_len = $urandom_range(2, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++) begin
            case ($urandom_range(0, 15))
                0:       tag_pool[i] = 32'h0000_0000;
                1:       tag_pool[i] = 32'hFFFF_FFFF;
                default: tag_pool[i] = $urandom;
            endcase
        end
    endtask

    task automatic random_access();
        logic [1:0]  cmd;
        logic [31:0] tag;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            cmd = lcsc_pkg::CMD_READ;
        else if (sel < 85)
            cmd = lcsc_pkg::CMD_WRITE;
        else if (sel < 97)
            cmd = lcsc_pkg::CMD_INVAL;
        else
            cmd = CMD_UNUSED;
        // mostly pool tags so lines get reused, some fresh ones as noise
        if ($urandom_range(0, 9) == 0)
            tag = $urandom;
        else
            tag = tag_pool[$urandom_range(0, pool_len - 1)];
        issue_access(cmd, tag);
    endtask

    initial begin
        int left;
        int chunk;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lcsc_pkg::CFG_WAYS_IN_USE;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        idle_cycles = 0;
        n_phase     = 0;
        gaps_on     = 1'b1;
        pool_len    = 1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, first on the reset costs and associativity
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0000);        // cold miss
        issue_access(lcsc_pkg::CMD_WRITE, 32'hFFFF_FFFF);       // miss, line goes dirty
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0000);        // hit
        issue_access(lcsc_pkg::CMD_INVAL, 32'hFFFF_FFFF);       // dirty line dropped, no cost
        issue_access(lcsc_pkg::CMD_INVAL, 32'h1234_5678);       // invalidate of an absent tag
        issue_access(CMD_UNUSED, 32'h0000_0000);                // ignored command
        // fill the remaining seven ways with dirty lines
        issue_access(lcsc_pkg::CMD_WRITE, 32'hA5A5_A5A5);
        issue_access(lcsc_pkg::CMD_WRITE, 32'h5A5A_5A5A);
        for (int t = 1; t <= 5; t++)
            issue_access(lcsc_pkg::CMD_WRITE, 32'(t));
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0000);        // clean line back to most recent
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0006);        // full set, dirty eviction

        // associativity below occupancy, costs at the top: each miss evicts
        configure(10'd2, 10'd1023, 10'd1023, 10'd1023);
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0007);
        issue_access(lcsc_pkg::CMD_WRITE, 32'h0000_0008);
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0000);

        // associativity 0 acts as a single way, all costs zero
        configure(10'd0, 10'd0, 10'd0, 10'd0);
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0007);
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0009);

        // associativity past the way count acts as the full set
        configure(10'h3FF, 10'd0, 10'd1023, 10'd0);
        issue_access(lcsc_pkg::CMD_WRITE, 32'h0000_000A);
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_000B);
        issue_access(lcsc_pkg::CMD_WRITE, 32'h8000_0001);
        issue_access(lcsc_pkg::CMD_READ, 32'h0000_0000);

        // random part in phases, each with its own registers, tag pool and idling
        left = RANDOM_ACCESSES;
        while (left > 0) begin
            configure(pick_ways_word(), pick_cost(), pick_cost(), pick_cost());
            refill_pool();
            gaps_on = ($urandom_range(0, 3) != 0);
            chunk   = $urandom_range(40, 140);
            if (chunk > left)
                chunk = left;
            for (int i = 0; i < chunk; i++)
                random_access();
            left -= chunk;
        end

        drain_set();
        $display("accesses checked: %0d over %0d register settings", n_access, n_phase);
        $display("hits %0d, evictions %0d of which dirty %0d",
                 n_hit, n_evict, n_dirty_evict);
        if (err_count == 0 && pending == 0) begin
            $display("lru_cache_set_with_cost_core_tb: done, clean");
        end else begin
            $display("lru_cache_set_with_cost_core_tb: done, errors");
        end
        $finish;
    end

endmodule
